>>> rtl/core/fcm_pkg.sv
// Shared types and sizing constants for the fixed-capacity multiset.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fcm_pkg;

  // Storage sizing
  localparam int CAPACITY  = 16;
  localparam int ITEM_BITS = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Fixed port field widths
  localparam int REQ_W   = 2;
  localparam int VALUE_W = 32;
  localparam int OUT_W   = 5;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_COUNT  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_code_t;

  // Input request as it arrives on the ports
  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [VALUE_W-1:0] item_value;
  } in_item_t;

  // Result as it leaves on the ports
  typedef struct packed {
    logic             ok;
    logic [OUT_W-1:0] copies;
    logic [OUT_W-1:0] size;
    logic             is_full;
    logic             is_empty;
  } out_item_t;

  // One-hot request class decided by the front end
  typedef struct packed {
    logic add;
    logic remove;
    logic count;
    logic clear;
  } op_class_t;

  // Classified request handed from front to back
  typedef struct packed {
    op_class_t            cls;
    logic [ITEM_BITS-1:0] value;
  } op_t;

endpackage : fcm_pkg

`default_nettype wire

>>> rtl/core/fcm_front.sv
// Front end: accepts requests, classifies them and buffers them in a
// two-entry queue for the back end. Depends on fcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcm_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire fcm_pkg::in_item_t request,
  output logic                  op_valid,
  input  wire logic             op_pop,
  output fcm_pkg::op_t          op
);
  import fcm_pkg::*;

  op_t        q_data [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic [1:0] q_cnt_next;
  op_t        classified;
  logic       do_push;
  logic       do_pop;

  // Decode the request code into a one-hot class, cast the value to ITEM_BITS
  always_comb begin
    classified.cls   = '0;
    classified.value = ITEM_BITS'(request.item_value);
    unique case (req_code_t'(request.req_type))
      REQ_ADD:    classified.cls.add    = 1'b1;
      REQ_REMOVE: classified.cls.remove = 1'b1;
      REQ_COUNT:  classified.cls.count  = 1'b1;
      REQ_CLEAR:  classified.cls.clear  = 1'b1;
      default:    classified.cls        = '0;
    endcase
  end

  assign full     = (q_cnt == 2'd2);
  assign op_valid = (q_cnt != 2'd0);
  assign op       = q_data[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = op_pop && op_valid;

  always_comb begin
    q_cnt_next = q_cnt;
    if (do_push && !do_pop) begin
      q_cnt_next = q_cnt + 2'd1;
    end else if (do_pop && !do_push) begin
      q_cnt_next = q_cnt - 2'd1;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      q_cnt <= q_cnt_next;
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_data[wr_ptr] <= classified;
    end
  end

endmodule : fcm_front

`default_nettype wire

>>> rtl/core/fcm_back.sv
// Back end: holds the entry store, matches a request against all held slots,
// applies it and queues the result. Depends on fcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcm_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              op_valid,
  output logic                   op_pop,
  input  wire fcm_pkg::op_t      op,
  output logic                   empty,
  input  wire logic              pop,
  output fcm_pkg::out_item_t     result
);
  import fcm_pkg::*;

  typedef enum logic [1:0] {
    S_MATCH = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t               state;
  state_t               state_next;

  // Entry store and occupancy
  logic [ITEM_BITS-1:0] store [CAPACITY];
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  // Request held between match and apply
  op_t                  cur;
  logic [CAPACITY-1:0]  match;
  logic [CAPACITY-1:0]  match_next;

  // Apply-stage signals
  logic [IDX_W-1:0]     first_idx;
  logic [IDX_W-1:0]     last_idx;
  logic [CNT_W-1:0]     hits;
  logic                 any_hit;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [ITEM_BITS-1:0] wr_data;
  out_item_t            res_item;
  logic                 res_push;

  // Result queue
  out_item_t            r_data [2];
  logic                 r_wr_ptr;
  logic                 r_rd_ptr;
  logic [1:0]           r_cnt;
  logic [1:0]           r_cnt_next;
  logic                 r_pop;

  // Compare every held slot with the request value
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      match_next[k] = (CNT_W'(k) < count) && (store[k] == op.value);
    end
  end

  // Lowest matching slot
  always_comb begin
    first_idx = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (match[k]) first_idx = IDX_W'(k);
    end
  end

  assign hits     = CNT_W'($countones(match));
  assign any_hit  = |match;
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign op_pop   = (state == S_MATCH) && op_valid;
  assign res_push = (state == S_APPLY) && (r_cnt != 2'd2);

  // Apply the held request
  always_comb begin
    count_next = count;
    wr_en      = 1'b0;
    wr_idx     = first_idx;
    wr_data    = store[last_idx];
    res_item   = '0;
    priority if (cur.cls.add) begin
      if (count < CNT_W'(CAPACITY)) begin
        count_next  = count + CNT_W'(1);
        wr_en       = 1'b1;
        wr_idx      = IDX_W'(count);
        wr_data     = cur.value;
        res_item.ok = 1'b1;
      end
    end else if (cur.cls.remove) begin
      if (any_hit) begin
        count_next  = count - CNT_W'(1);
        wr_en       = 1'b1;
        res_item.ok = 1'b1;
      end
    end else if (cur.cls.count) begin
      res_item.copies = OUT_W'(hits);
      res_item.ok     = any_hit;
    end else if (cur.cls.clear) begin
      count_next  = '0;
      res_item.ok = 1'b1;
    end
    res_item.size     = OUT_W'(count_next);
    res_item.is_full  = (count_next == CNT_W'(CAPACITY));
    res_item.is_empty = (count_next == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_MATCH: if (op_valid) state_next = S_APPLY;
      S_APPLY: if (res_push) state_next = S_MATCH;
      default: state_next = S_MATCH;
    endcase
  end

  // Sequencer and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_MATCH;
      count <= '0;
    end else begin
      state <= state_next;
      if (res_push) count <= count_next;
    end
  end

  // Match results and held request
  always_ff @(posedge clk) begin
    if (op_pop) begin
      cur   <= op;
      match <= match_next;
    end
  end

  // Entry store writes: add at the tail, remove moves the tail down
  always_ff @(posedge clk) begin
    if (res_push && wr_en) begin
      store[wr_idx] <= wr_data;
    end
  end

  // Result queue
  assign empty  = (r_cnt == 2'd0);
  assign result = r_data[r_rd_ptr];
  assign r_pop  = pop && !empty;

  always_comb begin
    r_cnt_next = r_cnt;
    if (res_push && !r_pop) begin
      r_cnt_next = r_cnt + 2'd1;
    end else if (r_pop && !res_push) begin
      r_cnt_next = r_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_wr_ptr <= 1'b0;
      r_rd_ptr <= 1'b0;
      r_cnt    <= 2'd0;
    end else begin
      r_cnt <= r_cnt_next;
      if (res_push) r_wr_ptr <= ~r_wr_ptr;
      if (r_pop)    r_rd_ptr <= ~r_rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      r_data[r_wr_ptr] <= res_item;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_MATCH) |=> (count == $past(count)))
    else $error("occupancy changed outside apply");

  a_apply_returns: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (state == S_MATCH))
    else $error("sequencer did not return after result push");

  a_no_pop_in_apply: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> !op_pop)
    else $error("request taken while another is being applied");

  a_result_fill: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (r_cnt != 2'd0))
    else $error("result lost after push");

endmodule : fcm_back

`default_nettype wire

>>> rtl/core/fixed_capacity_multiset_top.sv
// Top level of the fixed-capacity multiset: front end, request queue, back end.
// Depends on fcm_pkg, fcm_front and fcm_back.
// Requests pass from the request queue through the back end's match and apply
// steps; the back end takes no new request while it applies one.
// Reset: synchronous rst empties both queues and sets the occupancy to zero;
// the entry store is not cleared and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module fixed_capacity_multiset_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire fcm_pkg::in_item_t  request,
  output logic                    empty,
  input  wire logic               pop,
  output fcm_pkg::out_item_t      result
);
  import fcm_pkg::*;

  logic op_valid;
  logic op_pop;
  op_t  op;

  fcm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .op_valid (op_valid),
    .op_pop   (op_pop),
    .op       (op)
  );

  fcm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_pop   (op_pop),
    .op       (op),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule : fixed_capacity_multiset_top

`default_nettype wire
